// File: hw/rtl/tst_pkg.sv
`default_nettype none

package tst_pkg;

    // request codes on the input channel
    localparam logic [1:0] REQ_SUBSCRIBE   = 2'd0;
    localparam logic [1:0] REQ_UNSUBSCRIBE = 2'd1;
    localparam logic [1:0] REQ_PUBLISH     = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam int FIELD_ID_W    = 16;
    localparam int FIELD_TOPIC_W = 32;
    localparam int GEN_W         = 8;

    typedef enum logic [1:0] {
        K_INV,
        K_SUB,
        K_UNS,
        K_PUB
    } t_kind;

    // classified command handed from the front to the back
    typedef struct packed {
        t_kind                    kind;
        logic [FIELD_ID_W-1:0]    id;
        logic [FIELD_TOPIC_W-1:0] mask;
        logic [GEN_W-1:0]         gen;
        logic [7:0]               idx;
        logic                     release_all;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_UCHK,
        S_ONE
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/tst_front.sv
`default_nettype none

module tst_front
    import tst_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int TOPIC_BITS = 32,
    parameter int ID_BITS    = 16
) (
    input  wire logic [5:0]  i_topic_limit,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [15:0] i_subscriber_id,
    input  wire logic [31:0] i_topic_set,
    input  wire logic        i_release_all,
    input  wire logic [15:0] i_handle_in,
    input  wire logic [4:0]  i_topic,
    output t_cmd             o_cmd
);

    logic [31:0] allowed;
    logic [15:0] id_keep;
    logic [15:0] id_m;
    logic        mask_ok;
    logic        id_ok;
    logic [7:0]  idx8;
    logic        handle_ok;

    always_comb begin
        for (int j = 0; j < 32; j++) begin
            allowed[j] = (j < TOPIC_BITS) && (6'(j) < i_topic_limit);
        end
        for (int j = 0; j < 16; j++) begin
            id_keep[j] = (j < ID_BITS);
        end
    end

    assign id_m      = i_subscriber_id & id_keep;
    assign id_ok     = (id_m != 16'd0);
    assign mask_ok   = (i_topic_set != 32'd0) && ((i_topic_set & ~allowed) == 32'd0);
    assign idx8      = i_handle_in[7:0] - 8'd1;
    assign handle_ok = (i_handle_in != 16'd0) && (idx8 < 8'(SLOTS));

    always_comb begin
        o_cmd.id          = id_m;
        o_cmd.mask        = i_topic_set;
        o_cmd.gen         = i_handle_in[15:8];
        o_cmd.idx         = idx8;
        o_cmd.release_all = i_release_all;
        o_cmd.kind        = K_INV;
        unique case (i_req_type)
            REQ_SUBSCRIBE: begin
                o_cmd.kind = (id_ok && mask_ok) ? K_SUB : K_INV;
            end
            REQ_UNSUBSCRIBE: begin
                o_cmd.kind = (handle_ok && (i_release_all || mask_ok)) ? K_UNS : K_INV;
            end
            REQ_PUBLISH: begin
                o_cmd.kind = allowed[i_topic] ? K_PUB : K_INV;
                o_cmd.mask = 32'd1 << i_topic;
            end
            default: begin
                o_cmd.kind = K_INV;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/tst_queue.sv
`default_nettype none

module tst_queue
    import tst_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    // two-entry command queue
    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tst_back.sv
`default_nettype none

module tst_back
    import tst_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int TOPIC_BITS = 32,
    parameter int ID_BITS    = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  t_cmd             i_q_cmd,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_handle_out,
    output logic [15:0]      o_target_id,
    output logic             o_target_valid,
    output logic             o_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ID_W  = (ID_BITS < FIELD_ID_W) ? ID_BITS : FIELD_ID_W;
    localparam int MEM_W = GEN_W + ID_W + TOPIC_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // slot memory: generation, subscriber, topics
    logic [MEM_W-1:0] r_mem [SLOTS];
    logic [MEM_W-1:0] r_rdata;

    t_state                r_state;
    t_state                n_state;
    t_cmd                  r_cmd;
    logic [IDX_W-1:0]      r_ev;
    logic [SLOTS-1:0]      r_used;
    logic [SLOTS-1:0]      r_init;
    logic                  r_hit_v;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [GEN_W-1:0]      r_hit_gen;
    logic [TOPIC_BITS-1:0] r_hit_top;
    logic                  r_free_v;
    logic [IDX_W-1:0]      r_free_idx;
    logic [GEN_W-1:0]      r_free_gen;
    logic                  r_pend_v;
    logic [15:0]           r_pend_id;

    logic                  r_out_valid;
    logic [1:0]            r_out_status;
    logic [15:0]           r_out_handle;
    logic [15:0]           r_out_tid;
    logic                  r_out_tvalid;
    logic                  r_out_last;

    logic [GEN_W-1:0]      rd_gen;
    logic [ID_W-1:0]       rd_sub;
    logic [TOPIC_BITS-1:0] rd_top;
    logic [IDX_W-1:0]      u_idx;
    logic [IDX_W-1:0]      cur_idx;
    logic                  cur_used;
    logic [GEN_W-1:0]      cur_gen;
    logic [ID_W-1:0]       cmd_id;
    logic [TOPIC_BITS-1:0] cmd_mask;
    logic                  is_pub;
    logic                  scan_last;
    logic                  hit_now;
    logic                  pub_match;
    logic [TOPIC_BITS-1:0] new_top;
    logic [GEN_W-1:0]      gen_inc;
    logic [GEN_W-1:0]      gen_new;
    logic                  out_free;

    logic                  adv;
    logic [IDX_W-1:0]      rd_addr;
    logic                  out_load;
    logic [1:0]            n_status;
    logic [15:0]           n_handle;
    logic [15:0]           n_tid;
    logic                  n_tvalid;
    logic                  n_last;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_wa;
    logic [MEM_W-1:0]      mem_wd;
    logic                  take_slot;
    logic                  free_slot;

    assign rd_gen    = r_rdata[MEM_W-1 -: GEN_W];
    assign rd_sub    = r_rdata[TOPIC_BITS +: ID_W];
    assign rd_top    = r_rdata[TOPIC_BITS-1:0];
    assign u_idx     = r_cmd.idx[IDX_W-1:0];
    assign cur_idx   = (r_state == S_UCHK) ? u_idx : r_ev;
    assign cur_used  = r_used[cur_idx];
    assign cur_gen   = r_init[cur_idx] ? rd_gen : '0;
    assign cmd_id    = r_cmd.id[ID_W-1:0];
    assign cmd_mask  = r_cmd.mask[TOPIC_BITS-1:0];
    assign is_pub    = (r_cmd.kind == K_PUB);
    assign scan_last = (r_ev == LAST_IDX);
    assign hit_now   = cur_used && (rd_sub == cmd_id);
    assign pub_match = cur_used && (rd_sub != '0) && ((rd_top & cmd_mask) != '0);
    assign new_top   = r_cmd.release_all ? '0 : (rd_top & ~cmd_mask);
    assign gen_inc   = r_free_gen + 8'd1;
    assign gen_new   = (gen_inc == 8'd0) ? 8'd1 : gen_inc;
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_cmd.kind)
                        K_SUB, K_PUB: n_state = S_SCAN;
                        K_UNS:        n_state = S_UCHK;
                        K_INV:        n_state = S_ONE;
                        default:      n_state = S_ONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (adv && scan_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN, S_UCHK, S_ONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        adv       = 1'b0;
        rd_addr   = r_ev;
        out_load  = 1'b0;
        n_status  = ST_OK;
        n_handle  = 16'd0;
        n_tid     = 16'd0;
        n_tvalid  = 1'b0;
        n_last    = 1'b1;
        mem_we    = 1'b0;
        mem_wa    = r_ev;
        mem_wd    = '0;
        take_slot = 1'b0;
        free_slot = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_pop   = i_q_valid;
                rd_addr = (i_q_cmd.kind == K_UNS) ? i_q_cmd.idx[IDX_W-1:0] : '0;
            end
            S_SCAN: begin
                adv     = !(is_pub && pub_match && r_pend_v && !out_free);
                rd_addr = (adv && !scan_last) ? r_ev + 1'b1 : r_ev;
                if (is_pub && pub_match && r_pend_v && out_free) begin
                    out_load = 1'b1;
                    n_tid    = r_pend_id;
                    n_tvalid = 1'b1;
                    n_last   = 1'b0;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (is_pub) begin
                        n_tid    = r_pend_id;
                        n_tvalid = r_pend_v;
                    end else if (r_hit_v) begin
                        mem_we   = 1'b1;
                        mem_wa   = r_hit_idx;
                        mem_wd   = {r_hit_gen, cmd_id, r_hit_top | cmd_mask};
                        n_handle = {r_hit_gen, 8'(r_hit_idx) + 8'd1};
                    end else if (r_free_v) begin
                        mem_we    = 1'b1;
                        mem_wa    = r_free_idx;
                        mem_wd    = {gen_new, cmd_id, cmd_mask};
                        take_slot = 1'b1;
                        n_handle  = {gen_new, 8'(r_free_idx) + 8'd1};
                    end else begin
                        n_status = ST_FULL;
                    end
                end
            end
            S_UCHK: begin
                rd_addr = u_idx;
                if (out_free) begin
                    out_load = 1'b1;
                    if (!cur_used || (cur_gen != r_cmd.gen)) begin
                        n_status = ST_NOT_FOUND;
                    end else begin
                        free_slot = r_cmd.release_all || (new_top == '0);
                        mem_we    = 1'b1;
                        mem_wa    = u_idx;
                        mem_wd    = free_slot ? {cur_gen, {(ID_W + TOPIC_BITS){1'b0}}}
                                              : {cur_gen, rd_sub, new_top};
                    end
                end
            end
            S_ONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_status = ST_INVALID;
                end
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd     <= i_q_cmd;
            r_pend_id <= 16'd0;
        end else if ((r_state == S_SCAN) && adv && is_pub && pub_match) begin
            r_pend_id <= 16'(rd_sub);
        end
        if ((r_state == S_SCAN) && adv && !is_pub) begin
            if (hit_now && !r_hit_v) begin
                r_hit_idx <= r_ev;
                r_hit_gen <= cur_gen;
                r_hit_top <= rd_top;
            end
            if (!cur_used && !r_free_v) begin
                r_free_idx <= r_ev;
                r_free_gen <= cur_gen;
            end
        end
        if (out_load) begin
            r_out_status <= n_status;
            r_out_handle <= n_handle;
            r_out_tid    <= n_tid;
            r_out_tvalid <= n_tvalid;
            r_out_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ev        <= '0;
            r_used      <= '0;
            r_init      <= '0;
            r_hit_v     <= 1'b0;
            r_free_v    <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_ev     <= '0;
                r_hit_v  <= 1'b0;
                r_free_v <= 1'b0;
                r_pend_v <= 1'b0;
            end else if ((r_state == S_SCAN) && adv) begin
                if (!scan_last) begin
                    r_ev <= r_ev + 1'b1;
                end
                if (!is_pub && hit_now) begin
                    r_hit_v <= 1'b1;
                end
                if (!is_pub && !cur_used) begin
                    r_free_v <= 1'b1;
                end
                if (is_pub && pub_match) begin
                    r_pend_v <= 1'b1;
                end
            end
            if (mem_we) begin
                r_init[mem_wa] <= 1'b1;
            end
            if (take_slot) begin
                r_used[mem_wa] <= 1'b1;
            end
            if (free_slot) begin
                r_used[mem_wa] <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_handle_out   = r_out_handle;
    assign o_target_id    = r_out_tid;
    assign o_target_valid = r_out_tvalid;
    assign o_last         = r_out_last;

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((r_state == S_FIN) || (r_state == S_UCHK)))
        else $error("slot memory written outside a commit state");

    a_used_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_used & ~r_init) == '0))
        else $error("used slot with never written entry");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result register overwritten while stalled");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != S_IDLE))
        else $error("command popped but back stayed idle");

    a_not_last_pub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_out_tvalid && (r_out_status == ST_OK)))
        else $error("non-final result that is not a publish target");

endmodule

`default_nettype wire

// File: hw/rtl/topic_subscription_table_core.sv
`default_nettype none

// topic subscription table: SLOTS subscriber slots, each with a used flag, an 8-bit
// generation, a subscriber id and a topic mask. a request is classified on entry and
// parked in a two-deep command queue, so the input takes a new transfer while the back
// end works, until the queue is full. subscribe scans every slot once (one slot per cycle
// from the slot memory's single registered read port) and then commits; unsubscribe
// reads one slot and commits; publish scans every slot, waiting on result-side stalls,
// and sends one transfer per matching subscriber in slot order, or one with no target
// if none matches. results leave through an output register, one transfer per result,
// the final one flagged by o_last. the topic limit is to be written on its own port
// only while the block is idle, by the user; the block itself does not enforce this.

module topic_subscription_table_core
    import tst_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int TOPIC_BITS = 32,
    parameter int ID_BITS    = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [5:0]  i_cfg_data,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [15:0] i_subscriber_id,
    input  wire logic [31:0] i_topic_set,
    input  wire logic        i_release_all,
    input  wire logic [15:0] i_handle_in,
    input  wire logic [4:0]  i_topic,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_handle_out,
    output logic [15:0]      o_target_id,
    output logic             o_target_valid,
    output logic             o_last
);

    // topic limit register, reset to all topics
    logic [5:0] r_topic_limit;

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic in_xfer;

    // configuration writes always complete
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_topic_limit <= 6'd32;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_topic_limit <= i_cfg_data;
        end
    end

    // input transfer when valid and queue not full
    assign o_in_stall = q_full;
    assign in_xfer    = i_in_valid && !q_full;

    // front: check arguments against the current topic count
    tst_front #(
        .SLOTS      (SLOTS),
        .TOPIC_BITS (TOPIC_BITS),
        .ID_BITS    (ID_BITS)
    ) u_front (
        .i_topic_limit   (r_topic_limit),
        .i_req_type      (i_req_type),
        .i_subscriber_id (i_subscriber_id),
        .i_topic_set     (i_topic_set),
        .i_release_all   (i_release_all),
        .i_handle_in     (i_handle_in),
        .i_topic         (i_topic),
        .o_cmd           (front_cmd)
    );

    // command queue between front and back
    tst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // back: slot scans, table updates and result register
    tst_back #(
        .SLOTS      (SLOTS),
        .TOPIC_BITS (TOPIC_BITS),
        .ID_BITS    (ID_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_cmd),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_handle_out   (o_handle_out),
        .o_target_id    (o_target_id),
        .o_target_valid (o_target_valid),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tst_pkg::*;

    // request code outside the defined set, must be rejected
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int SLOT_COUNT   = 16;
    localparam int DRAIN_CYCLES = 40;      // longest scan plus output register, with margin
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PRINT_CAP    = 40;

    // one result transfer as seen on the output channel
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] handle;
        logic [15:0] target;
        logic        target_valid;
        logic        last;
    } t_reply;

    // mirror of the subscription table plus the replies it still owes
    class subscription_mirror;
        bit          used [SLOT_COUNT];
        logic [7:0]  gen [SLOT_COUNT];
        logic [15:0] owner [SLOT_COUNT];
        logic [31:0] topics [SLOT_COUNT];
        logic [5:0]  topic_limit;
        t_reply      owed_replies [$];
        int          errors;

        function new();
            for (int s = 0; s < SLOT_COUNT; s++) begin
                used[s]   = 1'b0;
                gen[s]    = 8'd0;
                owner[s]  = 16'd0;
                topics[s] = 32'd0;
            end
            topic_limit = 6'd32;
            errors      = 0;
        endfunction

        // effective topic count, clipped to the mask width
        function int live_count();
            return (topic_limit > 6'd32) ? 32 : int'(topic_limit);
        endfunction

        function logic [31:0] topic_window();
            if (live_count() >= 32) return 32'hFFFF_FFFF;
            return (32'd1 << live_count()) - 32'd1;
        endfunction

        function bit mask_fits(logic [31:0] m);
            return (m != 32'd0) && ((m & ~topic_window()) == 32'd0);
        endfunction

        function void owe(logic [1:0] st, logic [15:0] h, logic [15:0] id, logic v, logic l);
            t_reply r;
            r.status       = st;
            r.handle       = h;
            r.target       = id;
            r.target_valid = v;
            r.last         = l;
            owed_replies.push_back(r);
        endfunction

        // apply one accepted request to the table and queue its replies
        function void take_request(logic [1:0] req, logic [15:0] id, logic [31:0] mask,
                                   logic drop_all, logic [15:0] handle, logic [4:0] topic);
            int         n;
            int         k;
            logic [7:0] idx;
            logic [7:0] g;
            logic [7:0] tag;
            case (req)
                REQ_SUBSCRIBE: begin
                    if (id == 16'd0 || !mask_fits(mask)) begin
                        owe(ST_INVALID, 16'd0, 16'd0, 1'b0, 1'b1);
                        return;
                    end
                    // merge into the slot that already holds this subscriber
                    for (int s = 0; s < SLOT_COUNT; s++) begin
                        if (used[s] && owner[s] == id) begin
                            topics[s] = topics[s] | mask;
                            tag = 8'(s + 1);
                            owe(ST_OK, {gen[s], tag}, 16'd0, 1'b0, 1'b1);
                            return;
                        end
                    end
                    // otherwise take the lowest free slot, generation skips zero
                    for (int s = 0; s < SLOT_COUNT; s++) begin
                        if (!used[s]) begin
                            g = gen[s] + 8'd1;
                            if (g == 8'd0) g = 8'd1;
                            gen[s]    = g;
                            used[s]   = 1'b1;
                            owner[s]  = id;
                            topics[s] = mask;
                            tag = 8'(s + 1);
                            owe(ST_OK, {g, tag}, 16'd0, 1'b0, 1'b1);
                            return;
                        end
                    end
                    owe(ST_FULL, 16'd0, 16'd0, 1'b0, 1'b1);
                end
                REQ_UNSUBSCRIBE: begin
                    idx = handle[7:0] - 8'd1;
                    if (handle == 16'd0 || idx >= SLOT_COUNT || (!drop_all && !mask_fits(mask)))
                    begin
                        owe(ST_INVALID, 16'd0, 16'd0, 1'b0, 1'b1);
                    end else if (!used[idx[3:0]] || gen[idx[3:0]] != handle[15:8]) begin
                        owe(ST_NOT_FOUND, 16'd0, 16'd0, 1'b0, 1'b1);
                    end else begin
                        if (!drop_all) topics[idx[3:0]] = topics[idx[3:0]] & ~mask;
                        // an emptied slot is freed, generation kept
                        if (drop_all || topics[idx[3:0]] == 32'd0) begin
                            used[idx[3:0]]   = 1'b0;
                            owner[idx[3:0]]  = 16'd0;
                            topics[idx[3:0]] = 32'd0;
                        end
                        owe(ST_OK, 16'd0, 16'd0, 1'b0, 1'b1);
                    end
                end
                REQ_PUBLISH: begin
                    if (topic >= live_count()) begin
                        owe(ST_INVALID, 16'd0, 16'd0, 1'b0, 1'b1);
                        return;
                    end
                    n = 0;
                    for (int s = 0; s < SLOT_COUNT; s++)
                        if (used[s] && owner[s] != 16'd0 && topics[s][topic]) n++;
                    if (n == 0) begin
                        owe(ST_OK, 16'd0, 16'd0, 1'b0, 1'b1);
                        return;
                    end
                    // one transfer per matching slot, in slot order
                    k = 0;
                    for (int s = 0; s < SLOT_COUNT; s++) begin
                        if (used[s] && owner[s] != 16'd0 && topics[s][topic]) begin
                            k++;
                            owe(ST_OK, 16'd0, owner[s], 1'b1, k == n);
                        end
                    end
                end
                default: begin
                    owe(ST_INVALID, 16'd0, 16'd0, 1'b0, 1'b1);
                end
            endcase
        endfunction

        task flag_mismatch(string what);
            errors++;
            if (errors <= PRINT_CAP) $display("%0t mismatch: %s", $realtime, what);
        endtask

        // compare one result transfer with the oldest owed reply
        task match_reply(logic [1:0] st, logic [15:0] h, logic [15:0] id, logic v, logic l);
            t_reply want;
            if (owed_replies.size() == 0) begin
                flag_mismatch($sformatf("result with nothing owed (status %0d id %h)", st, id));
                return;
            end
            want = owed_replies.pop_front();
            if (st !== want.status)
                flag_mismatch($sformatf("status %0d, want %0d", st, want.status));
            if (h !== want.handle)
                flag_mismatch($sformatf("handle %h, want %h", h, want.handle));
            if (id !== want.target)
                flag_mismatch($sformatf("target id %h, want %h", id, want.target));
            if (v !== want.target_valid)
                flag_mismatch($sformatf("target valid %b, want %b", v, want.target_valid));
            if (l !== want.last)
                flag_mismatch($sformatf("last %b, want %b", l, want.last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [5:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_req_type;
    logic [15:0] i_subscriber_id;
    logic [31:0] i_topic_set;
    logic        i_release_all;
    logic [15:0] i_handle_in;
    logic [4:0]  i_topic;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic [15:0] o_handle_out;
    logic [15:0] o_target_id;
    logic        o_target_valid;
    logic        o_last;

    subscription_mirror mirror;
    int                 sender_idle_pct = 0;
    int                 stall_pct       = 0;
    int                 cycle_count     = 0;
    logic [15:0]        id_pool [24];

    topic_subscription_table_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_subscriber_id(i_subscriber_id),
        .i_topic_set    (i_topic_set),
        .i_release_all  (i_release_all),
        .i_handle_in    (i_handle_in),
        .i_topic        (i_topic),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_handle_out   (o_handle_out),
        .o_target_id    (o_target_id),
        .o_target_valid (o_target_valid),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side backpressure, independent of o_out_valid
    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // sample both channels at the edge: a transfer happens when valid is high and stall low
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                mirror.take_request(i_req_type, i_subscriber_id, i_topic_set, i_release_all,
                                    i_handle_in, i_topic);
            if (o_out_valid && !i_out_stall)
                mirror.match_reply(o_status, o_handle_out, o_target_id, o_target_valid, o_last);
        end
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // present one request, with a random gap first, and hold it until the transfer
    task automatic send_request(input logic [1:0] req, input logic [15:0] id,
                                input logic [31:0] mask, input logic drop_all,
                                input logic [15:0] handle, input logic [4:0] topic);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_subscriber_id <= id;
        i_topic_set     <= mask;
        i_release_all   <= drop_all;
        i_handle_in     <= handle;
        i_topic         <= topic;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop sending and let every owed reply come back, then let the back end settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (mirror.owed_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // only called while idle
    task automatic write_topic_limit(input logic [5:0] count);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mirror.topic_limit = count;
    endtask

    // mostly well-formed requests aimed at live slots, the rest noise
    task automatic random_request();
        int          pick;
        int          s;
        int          cnt;
        logic [31:0] window;
        logic [1:0]  req;
        logic [15:0] id;
        logic [15:0] handle;
        logic [31:0] mask;
        logic        drop_all;
        logic [4:0]  topic;
        logic [7:0]  tag;
        cnt      = mirror.live_count();
        window   = mirror.topic_window();
        pick     = $urandom_range(99);
        id       = id_pool[$urandom_range(23)];
        mask     = $urandom;
        drop_all = 1'($urandom_range(1));
        handle   = 16'($urandom);
        topic    = 5'($urandom);
        if (pick < 3) begin
            req = REQ_UNUSED;
        end else if (pick < 45) begin
            req = REQ_SUBSCRIBE;
            if ($urandom_range(19) == 0) id = 16'd0;
            else if ($urandom_range(19) == 0) id = 16'($urandom);
            if ($urandom_range(9) < 8)
                mask = ((32'd1 << $urandom_range(cnt - 1)) | ($urandom & $urandom)) & window;
            else if ($urandom_range(3) == 0)
                mask = 32'd0;
        end else if (pick < 72) begin
            req = REQ_UNSUBSCRIBE;
            s   = $urandom_range(SLOT_COUNT - 1);
            tag = 8'(s + 1);
            pick = $urandom_range(19);
            // keep the random handle now and then, else aim at a slot, sometimes stale
            if (pick > 2) handle = {mirror.gen[s], tag};
            if (pick == 3 || pick == 4) handle[15:8] = handle[15:8] + 8'd1;
            drop_all = ($urandom_range(2) == 0);
            pick = $urandom_range(9);
            if (pick < 5)
                mask = mirror.topics[s];
            else if (pick < 8)
                mask = ((32'd1 << $urandom_range(cnt - 1)) | ($urandom & $urandom)) & window;
        end else begin
            req = REQ_PUBLISH;
            if ($urandom_range(4) != 0) topic = 5'($urandom_range(cnt - 1));
        end
        send_request(req, id, mask, drop_all, handle, topic);
    endtask

    task automatic run_random(input int count);
        for (int k = 0; k < count; k++) random_request();
    endtask

    // release every live slot
    task automatic free_table();
        logic [7:0] tag;
        wait_idle();
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if (mirror.used[s]) begin
                tag = 8'(s + 1);
                send_request(REQ_UNSUBSCRIBE, 16'd0, 32'd0, 1'b1, {mirror.gen[s], tag}, 5'd0);
            end
        end
    endtask

    // take and free slot 0 over and over, its generation advancing each round
    task automatic cycle_generations(input int rounds);
        logic [7:0]  g;
        logic [15:0] id;
        logic [31:0] mask;
        wait_idle();
        g = mirror.gen[0];
        for (int r = 0; r < rounds; r++) begin
            g    = (g == 8'hFF) ? 8'h01 : g + 8'd1;
            id   = 16'($urandom_range(65535, 1));
            mask = $urandom & mirror.topic_window();
            if (mask == 32'd0) mask = 32'd1;
            send_request(REQ_SUBSCRIBE, id, mask, 1'b0, 16'd0, 5'd0);
            // alternate a full release with a partial one that empties the slot
            if (r % 2)
                send_request(REQ_UNSUBSCRIBE, 16'd0, mask, 1'b0, {g, 8'h01}, 5'd0);
            else
                send_request(REQ_UNSUBSCRIBE, 16'd0, $urandom, 1'b1, {g, 8'h01}, 5'd0);
        end
    endtask

    initial begin
        mirror = new();
        foreach (id_pool[k]) id_pool[k] = 16'($urandom_range(65535, 1));
        id_pool[0] = 16'hFFFF;

        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= 6'd32;
        i_in_valid      <= 1'b0;
        i_req_type      <= REQ_SUBSCRIBE;
        i_subscriber_id <= 16'd0;
        i_topic_set     <= 32'd0;
        i_release_all   <= 1'b0;
        i_handle_in     <= 16'd0;
        i_topic         <= 5'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_topic_limit(6'd32);

        // directed pass, full topic range, no idling
        send_request(REQ_SUBSCRIBE, 16'h0000, 32'h0000_0001, 1'b0, 16'h0000, 5'd0);  // no id
        send_request(REQ_SUBSCRIBE, 16'hFFFF, 32'h0000_0000, 1'b0, 16'h0000, 5'd0);  // no topics
        send_request(REQ_SUBSCRIBE, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 16'h0000, 5'd0);  // slot 0
        send_request(REQ_SUBSCRIBE, 16'h0001, 32'h0000_0001, 1'b0, 16'h0000, 5'd0);  // slot 1
        send_request(REQ_SUBSCRIBE, 16'h0001, 32'h8000_0000, 1'b0, 16'h0000, 5'd0);  // merge
        send_request(REQ_PUBLISH,   16'h0000, 32'h0000_0000, 1'b0, 16'h0000, 5'd0);
        send_request(REQ_PUBLISH,   16'h0000, 32'h0000_0000, 1'b0, 16'h0000, 5'd31);
        send_request(REQ_PUBLISH,   16'h0000, 32'h0000_0000, 1'b0, 16'h0000, 5'd7);
        send_request(REQ_UNSUBSCRIBE, 16'h0000, 32'h0000_0001, 1'b1, 16'h0000, 5'd0); // zero handle
        send_request(REQ_UNSUBSCRIBE, 16'h0000, 32'h0000_0001, 1'b1, 16'h0111, 5'd0); // index past end
        send_request(REQ_UNSUBSCRIBE, 16'h0000, 32'h0000_0001, 1'b1, 16'hFFFF, 5'd0); // index wraps
        send_request(REQ_UNSUBSCRIBE, 16'h0000, 32'h0000_0000, 1'b1, 16'h0201, 5'd0); // wrong gen
        send_request(REQ_UNSUBSCRIBE, 16'h0000, 32'h0000_0000, 1'b1, 16'h0103, 5'd0); // free slot
        send_request(REQ_UNSUBSCRIBE, 16'h0000, 32'h0000_0000, 1'b0, 16'h0102, 5'd0); // empty mask
        send_request(REQ_UNSUBSCRIBE, 16'h0000, 32'h0000_0001, 1'b0, 16'h0102, 5'd0); // partial
        send_request(REQ_UNSUBSCRIBE, 16'h0000, 32'h8000_0000, 1'b0, 16'h0102, 5'd0); // empties
        send_request(REQ_UNSUBSCRIBE, 16'h0000, 32'h0000_0000, 1'b1, 16'h0101, 5'd0); // release all
        send_request(REQ_PUBLISH,   16'h0000, 32'h0000_0000, 1'b0, 16'h0000, 5'd0);  // no match
        send_request(REQ_UNUSED,    16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 5'd31);
        send_request(REQ_SUBSCRIBE, 16'h5A5A, 32'h0000_FFFF, 1'b0, 16'h0000, 5'd0);  // gen 2
        send_request(REQ_UNSUBSCRIBE, 16'h0000, 32'h0000_0000, 1'b1, 16'h0101, 5'd0); // stale
        run_random(40);

        // single topic, sender mostly idle
        wait_idle();
        write_topic_limit(6'd1);
        sender_idle_pct = 83;
        run_random(35);

        // partial topic range, receiver mostly stalled, with a full drain midway
        wait_idle();
        write_topic_limit(6'd20);
        sender_idle_pct = 0;
        stall_pct       = 83;
        run_random(15);
        wait_idle();
        run_random(20);

        // full range again, light idling on both sides
        wait_idle();
        write_topic_limit(6'd32);
        sender_idle_pct = 23;
        stall_pct       = 23;
        free_table();
        // seventeen new subscribers: the last one finds the table full
        for (int k = 0; k <= SLOT_COUNT; k++)
            send_request(REQ_SUBSCRIBE, 16'hC000 | 16'(k), 32'd1 << k, 1'b0, 16'h0000, 5'd0);
        run_random(25);
        free_table();
        cycle_generations(8);

        wait_idle();
        if (mirror.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
